/* hdl/rnc_pkg.sv */
// Shared types, codes and lookup functions for the Roman numeral converter.
// No dependencies; imported by roman_numeral_converter.
package rnc_pkg;

    // request kind, carried on the slave tuser bit
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic [11:0] MAX_NUMBER = 12'd3999;

    typedef logic [7:0] t_char;
    typedef logic [1:0] t_sym;
    typedef logic [1:0] t_place;

    // symbol within one decimal place
    localparam t_sym SYM_ONE  = 2'd0;
    localparam t_sym SYM_FIVE = 2'd1;
    localparam t_sym SYM_TEN  = 2'd2;

    // decimal places, most significant first
    localparam t_place PLACE_THOUSANDS = 2'd0;
    localparam t_place PLACE_HUNDREDS  = 2'd1;
    localparam t_place PLACE_TENS      = 2'd2;
    localparam t_place PLACE_UNITS     = 2'd3;

    localparam t_char CH_NONE = 8'h00;
    localparam t_char CH_I    = 8'h49;
    localparam t_char CH_V    = 8'h56;
    localparam t_char CH_X    = 8'h58;
    localparam t_char CH_L    = 8'h4C;
    localparam t_char CH_C    = 8'h43;
    localparam t_char CH_D    = 8'h44;
    localparam t_char CH_M    = 8'h4D;

    typedef struct packed {
        logic [9:0] value;
        logic [2:0] rank;
    } t_letter_info;

    typedef struct packed {
        t_char       letter;
        logic        last;
        logic [15:0] value;
        logic        is_decoded;
        logic        range_error;
    } t_result;

    function automatic t_letter_info letter_info(input t_char c);
        t_letter_info li;
        unique case (c)
            CH_I:    li = '{value: 10'd1,    rank: 3'd1};
            CH_V:    li = '{value: 10'd5,    rank: 3'd2};
            CH_X:    li = '{value: 10'd10,   rank: 3'd3};
            CH_L:    li = '{value: 10'd50,   rank: 3'd4};
            CH_C:    li = '{value: 10'd100,  rank: 3'd5};
            CH_D:    li = '{value: 10'd500,  rank: 3'd6};
            CH_M:    li = '{value: 10'd1000, rank: 3'd7};
            default: li = '{value: 10'd0,    rank: 3'd0};
        endcase
        return li;
    endfunction

    // number of letters one decimal digit takes
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] n;
        unique case (d)
            4'd1, 4'd5:       n = 3'd1;
            4'd2, 4'd4, 4'd6,
            4'd9:             n = 3'd2;
            4'd3, 4'd7:       n = 3'd3;
            4'd8:             n = 3'd4;
            default:          n = 3'd0;
        endcase
        return n;
    endfunction

    // symbol at position pos of the pattern for digit d
    function automatic t_sym digit_sym(input logic [3:0] d, input logic [1:0] pos);
        t_sym s;
        s = SYM_ONE;
        if (d == 4'd4) begin
            s = (pos == 2'd0) ? SYM_ONE : SYM_FIVE;
        end else if (d == 4'd9) begin
            s = (pos == 2'd0) ? SYM_ONE : SYM_TEN;
        end else if (d >= 4'd5) begin
            s = (pos == 2'd0) ? SYM_FIVE : SYM_ONE;
        end
        return s;
    endfunction

    function automatic t_char sym_char(input t_place place, input t_sym s);
        t_char c;
        c = CH_NONE;
        unique case (place)
            PLACE_THOUSANDS: c = CH_M;
            PLACE_HUNDREDS:  c = (s == SYM_ONE) ? CH_C : ((s == SYM_FIVE) ? CH_D : CH_M);
            PLACE_TENS:      c = (s == SYM_ONE) ? CH_X : ((s == SYM_FIVE) ? CH_L : CH_C);
            PLACE_UNITS:     c = (s == SYM_ONE) ? CH_I : ((s == SYM_FIVE) ? CH_V : CH_X);
            default:         c = CH_NONE;
        endcase
        return c;
    endfunction

    // 32-bit signed add of a small signed delta, saturating at the limits
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [10:0] d);
        logic [32:0] ext;
        logic [31:0] r;
        ext = {a[31], a} + {{22{d[10]}}, d};
        if (ext[32] != ext[31]) begin
            r = ext[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = ext[31:0];
        end
        return r;
    endfunction

endpackage

/* hdl/roman_numeral_converter.sv */
// Two-way Roman numeral converter: number to ASCII letters and letters to number.
// Depends on rnc_pkg.
//
// Encode requests (tuser 0) carry a number in tdata[11:0] and come out as one ASCII
// letter per output beat, thousands first, with tlast on the final letter; zero and
// numbers above 3999 give a single empty beat (range error flagged for the latter).
// Decode requests (tuser 1) carry one letter in tdata[19:12], tlast on the final one;
// only the final letter gives a beat, holding the clamped sum in tdata[23:8].
// The block takes one request per cycle unless the emitter or the output stalls it.
// A result passes through the input, digit, emitter and output registers. An encode
// request holds the emitter until its last letter (up to 15) is sent, which sets the
// rate for long numerals; decode and single-beat requests flow at one per cycle.
module roman_numeral_converter
    import rnc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [11:0] number, [19:12] letter, [23:20] zero
    input  logic        i_s_axis_tlast,  // letter_last
    input  logic        i_s_axis_tuser,  // [0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // [7:0] out_letter, [23:8] decoded_value
    output logic        o_m_axis_tlast,  // run_last
    output logic [1:0]  o_m_axis_tuser   // [0] is_decoded, [1] range_error
);

    // input stage
    logic        r_a_valid;
    logic        r_a_func;
    logic [11:0] r_a_number;
    t_char       r_a_letter;
    logic        r_a_last;

    // decode state
    logic [9:0]  r_held_value;
    logic [2:0]  r_held_rank;
    logic        r_held_valid;
    logic [31:0] r_sum;

    // digit stage
    logic        r_b_valid;
    logic        r_b_decode;
    logic        r_b_err;
    logic        r_b_zero;
    logic [1:0]  r_b_th;
    logic [3:0]  r_b_h;
    logic [9:0]  r_b_rem;
    logic [31:0] r_b_sum;
    logic [9:0]  r_b_val;

    // emitter stage
    logic        r_c_valid;
    logic        r_c_single;
    t_result     r_c_res;
    logic [3:0]  r_c_dig [4];
    t_place      r_c_idx;
    logic [1:0]  r_c_pos;

    // output register
    logic        r_o_valid;
    t_result     r_o_res;

    logic o_free, c_emit, c_done, c_free, b_free, a_free, a_adv;

    // ---------------- input stage logic ----------------
    t_letter_info a_li;
    logic [10:0]  a_delta;
    logic [31:0]  a_sum1;
    logic         a_err;
    logic [1:0]   a_th;
    logic [11:0]  a_thv;
    logic [9:0]   a_rem;
    logic [15:0]  a_hprod;
    logic         a_to_b;

    always_comb begin
        a_li    = letter_info(r_a_letter);
        a_delta = (r_held_rank < a_li.rank) ? (11'd0 - {1'b0, r_held_value})
                                            : {1'b0, r_held_value};
        a_sum1  = r_held_valid ? sat_add(r_sum, a_delta) : r_sum;
        a_err   = r_a_number > MAX_NUMBER;
        if (r_a_number >= 12'd3000) begin
            a_th = 2'd3;
        end else if (r_a_number >= 12'd2000) begin
            a_th = 2'd2;
        end else if (r_a_number >= 12'd1000) begin
            a_th = 2'd1;
        end else begin
            a_th = 2'd0;
        end
        a_thv   = 12'(a_th * 12'd1000);
        a_rem   = 10'(r_a_number - a_thv);
        // rem / 100 for rem < 1000
        a_hprod = 16'(a_rem * 16'd41);
        a_to_b  = (r_a_func == FUNC_ENCODE) || r_a_last;
    end

    // ---------------- digit stage logic ----------------
    logic [9:0]  b_hx;
    logic [6:0]  b_r2;
    logic [14:0] b_tprod;
    logic [3:0]  b_t;
    logic [3:0]  b_u;
    logic [31:0] b_sum2;
    logic [15:0] b_dv;
    logic [3:0]  b_dig [4];
    t_place      b_first;
    logic        b_single;

    always_comb begin
        b_hx    = 10'(r_b_h * 10'd100);
        b_r2    = 7'(r_b_rem - b_hx);
        b_tprod = 15'(b_r2 * 15'd205);
        b_t     = b_tprod[14:11];
        b_u     = 4'(b_r2 - 7'(b_t * 7'd10));
        b_sum2  = sat_add(r_b_sum, {1'b0, r_b_val});
        if (b_sum2[31]) begin
            b_dv = 16'd0;
        end else if (|b_sum2[30:16]) begin
            b_dv = 16'hFFFF;
        end else begin
            b_dv = b_sum2[15:0];
        end
        b_dig[PLACE_THOUSANDS] = {2'b00, r_b_th};
        b_dig[PLACE_HUNDREDS]  = r_b_h;
        b_dig[PLACE_TENS]      = b_t;
        b_dig[PLACE_UNITS]     = b_u;
        b_first = PLACE_UNITS;
        for (int i = 3; i >= 0; i--) begin
            if (b_dig[i] != 4'd0) begin
                b_first = t_place'(i);
            end
        end
        b_single = r_b_decode || r_b_err || r_b_zero;
    end

    // ---------------- emitter logic ----------------
    logic [3:0]  c_d;
    t_sym        c_sym;
    logic        c_digit_end;
    logic        c_has_next;
    t_place      c_next;
    logic        c_last;
    t_result     c_res;

    always_comb begin
        c_d         = r_c_dig[r_c_idx];
        c_sym       = digit_sym(c_d, r_c_pos);
        c_digit_end = ({1'b0, r_c_pos} + 3'd1) == digit_len(c_d);
        c_has_next  = 1'b0;
        c_next      = r_c_idx;
        // lowest later place with a nonzero digit
        for (int i = 3; i >= 0; i--) begin
            if ((r_c_dig[i] != 4'd0) && (3'(i) > {1'b0, r_c_idx})) begin
                c_has_next = 1'b1;
                c_next     = t_place'(i);
            end
        end
        c_last = r_c_single || (c_digit_end && !c_has_next);
        if (r_c_single) begin
            c_res = r_c_res;
        end else begin
            c_res = '{letter: sym_char(r_c_idx, c_sym), last: c_last, value: 16'd0,
                      is_decoded: 1'b0, range_error: 1'b0};
        end
    end

    // ---------------- flow control ----------------
    assign o_free = !r_o_valid || i_m_axis_tready;
    assign c_emit = r_c_valid && o_free;
    assign c_done = c_emit && c_last;
    assign c_free = !r_c_valid || c_done;
    assign b_free = !r_b_valid || c_free;
    assign a_free = !r_a_valid || b_free;
    assign a_adv  = r_a_valid && b_free;

    assign o_s_axis_tready = a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_c_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
            r_held_value <= '0;
            r_held_rank  <= '0;
            r_held_valid <= 1'b0;
            r_sum        <= '0;
        end else begin
            // input register
            if (a_free) begin
                r_a_valid <= i_s_axis_tvalid;
            end

            // decode state advances as the request leaves the input register
            if (a_adv && (r_a_func == FUNC_DECODE)) begin
                if (r_a_last) begin
                    r_held_value <= '0;
                    r_held_rank  <= '0;
                    r_held_valid <= 1'b0;
                    r_sum        <= '0;
                end else begin
                    r_held_value <= a_li.value;
                    r_held_rank  <= a_li.rank;
                    r_held_valid <= 1'b1;
                    r_sum        <= a_sum1;
                end
            end

            // non-final letters produce nothing, so drop them here
            if (b_free) begin
                r_b_valid <= a_adv && a_to_b;
            end

            if (c_free) begin
                r_c_valid <= r_b_valid;
            end else if (c_emit && !c_last) begin
                r_c_valid <= 1'b1;
            end

            if (o_free) begin
                r_o_valid <= c_emit;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && a_free) begin
            r_a_func   <= i_s_axis_tuser;
            r_a_number <= i_s_axis_tdata[11:0];
            r_a_letter <= i_s_axis_tdata[19:12];
            r_a_last   <= i_s_axis_tlast;
        end

        if (a_adv) begin
            r_b_decode <= r_a_func == FUNC_DECODE;
            r_b_err    <= a_err;
            r_b_zero   <= r_a_number == 12'd0;
            r_b_th     <= a_th;
            r_b_h      <= a_hprod[15:12];
            r_b_rem    <= a_rem;
            r_b_sum    <= a_sum1;
            r_b_val    <= a_li.value;
        end

        if (r_b_valid && c_free) begin
            r_c_single <= b_single;
            r_c_res    <= '{letter: CH_NONE, last: 1'b1,
                            value: r_b_decode ? b_dv : 16'd0,
                            is_decoded: r_b_decode,
                            range_error: !r_b_decode && r_b_err};
            for (int i = 0; i < 4; i++) begin
                r_c_dig[i] <= b_dig[i];
            end
            r_c_idx <= b_first;
            r_c_pos <= 2'd0;
        end else if (c_emit && !c_last) begin
            // advance within the digit or hop to the next nonzero place
            if (c_digit_end) begin
                r_c_idx <= c_next;
                r_c_pos <= 2'd0;
            end else begin
                r_c_pos <= r_c_pos + 2'd1;
            end
        end

        if (c_emit) begin
            r_o_res <= c_res;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o_res.value, r_o_res.letter};
    assign o_m_axis_tlast  = r_o_res.last;
    assign o_m_axis_tuser  = {r_o_res.range_error, r_o_res.is_decoded};

`ifndef SYNTHESIS
    // the emitter never points at a place that has no letters
    a_emit_digit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && !r_c_single) |-> (c_d != 4'd0))
        else $error("emitter points at an empty digit");

    // with no held letter the decode state is back at reset
    a_decode_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held_valid |-> ((r_held_rank == 3'd0) && (r_sum == 32'd0)))
        else $error("decode state not cleared");

    // decoded and out-of-range beats carry no letter and close the run
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_res.is_decoded || r_o_res.range_error))
            |-> ((r_o_res.letter == CH_NONE) && r_o_res.last))
        else $error("empty beat carries a letter or is not last");

    // a finished run releases the emitter when no request waits in the digit stage
    a_emit_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_done && !r_b_valid) |=> !r_c_valid)
        else $error("emitter did not release after last letter");
`endif

endmodule
